### rtl/wtl_pkg.sv
// ----------------------------------------------------------------------------
// wtl_pkg: shared definitions for the lowercasing word tokenizer
// Holds the size constants, the controller/datapath interface structs and
// the byte classification helpers.
// ----------------------------------------------------------------------------
package wtl_pkg;

  // Longest word kept, in characters; later characters are dropped.
  localparam int MAX_WORD_CHARS = 31;
  // Highest word number handed out.
  localparam int MAX_WORDS      = 65535;

  localparam int BYTE_W = 8;
  localparam int NUM_W  = 16;
  localparam int CNT_W  = $clog2(MAX_WORD_CHARS + 1);
  localparam int IDX_W  = $clog2(MAX_WORD_CHARS);

  // The word number stops at the smaller of the word limit and the field range.
  localparam int NUM_MAX = (1 << NUM_W) - 1;
  localparam logic [NUM_W-1:0] WORD_LIMIT =
    NUM_W'((MAX_WORDS < NUM_MAX) ? MAX_WORDS : NUM_MAX);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;    // an input byte transfers this cycle
    logic emit;    // load the next stored character into the output register
    logic finish;  // the emitted character is the last one of the word
  } wtl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic word_ready;  // the offered byte closes a word that will be sent
    logic last_char;   // the read pointer sits on the last stored character
    logic out_free;    // the output register can take a new character
  } wtl_sts_t;

  // True for every byte that ends a word.
  function automatic logic is_separator(input logic [BYTE_W-1:0] b);
    logic sep;
    begin
      case (b) inside
        8'h00, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h20, 8'h21, 8'h22, 8'h23,
        8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C,
        8'h2D, 8'h2E, 8'h2F, [8'h30:8'h39], 8'h3A, 8'h3B, 8'h3C, 8'h3D,
        8'h3E, 8'h3F, 8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h5F, 8'hA0: sep = 1'b1;
        default: sep = 1'b0;
      endcase
      return sep;
    end
  endfunction

  // Only the letters A to Z change case.
  function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    begin
      r = b;
      if (b >= 8'h41 && b <= 8'h5A) begin
        r = b + 8'h20;
      end
      return r;
    end
  endfunction

endpackage

### rtl/word_tokenizer_lowercase_top.sv
// ----------------------------------------------------------------------------
// word_tokenizer_lowercase_top: lowercasing word tokenizer
// Splits a byte stream into words at separator bytes, lowercases them and
// sends each word of two or more characters out one character at a time.
//
//   channel  direction  transfer                     payload
//   in_      input      in_valid & in_ready          text_byte, end_of_text
//   out_     output     out_valid & out_ready        byte, word_number,
//                                                    word_end, cut_short
//
// A byte that does not close a sent word leaves the controller idle. A byte
// that closes a word starts a send: the controller reads the store one entry
// per cycle into the output register while the output is free.
// Input is held off while a word is being sent; a stalled output stretches it.
// Reset is synchronous and active low; the store holds no reset value.
// ----------------------------------------------------------------------------
module word_tokenizer_lowercase_top
  import wtl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_text_byte,
  input  logic              in_end_of_text,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic [NUM_W-1:0]  out_word_number,
  output logic              out_word_end,
  output logic              out_cut_short
);

  wtl_cmd_t cmd;
  wtl_sts_t sts;

  // Sequencing.
  wtl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Word store and output register.
  wtl_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_text_byte    (in_text_byte),
    .in_end_of_text  (in_end_of_text),
    .out_ready       (out_ready),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .out_word_number (out_word_number),
    .out_word_end    (out_word_end),
    .out_cut_short   (out_cut_short)
  );

endmodule

### rtl/wtl_dp.sv
// ----------------------------------------------------------------------------
// wtl_dp: tokenizer datapath
// Word store, character count, overflow flag, word counter, read pointer
// and the output register with its valid flag.
// ----------------------------------------------------------------------------
module wtl_dp
  import wtl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] in_text_byte,
  input  logic              in_end_of_text,
  input  logic              out_ready,
  input  wtl_cmd_t          cmd,
  output wtl_sts_t          sts,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_byte,
  output logic [NUM_W-1:0]  out_word_number,
  output logic              out_word_end,
  output logic              out_cut_short
);

  // Characters of the pending word.
  logic [BYTE_W-1:0] store_mem [MAX_WORD_CHARS];

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [NUM_W-1:0]  words_r, words_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic [NUM_W-1:0]  out_num_r;
  logic              out_end_r;
  logic              out_cut_r;

  logic sep;
  logic closes;
  logic room;

  // Classify the offered byte.
  always_comb begin
    sep    = is_separator(in_text_byte);
    closes = sep || in_end_of_text;
    room   = (count_r < CNT_W'(MAX_WORD_CHARS));
  end

  // Status toward the controller.
  always_comb begin
    sts.word_ready = sep ? (count_r >= CNT_W'(2))
                         : (in_end_of_text && (count_r != '0));
    sts.last_char  = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // Next values of the word state.
  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    words_nxt     = words_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;

    if (cmd.take) begin
      if (!sep) begin
        if (room) begin
          count_nxt = count_r + CNT_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      if (sts.word_ready) begin
        idx_nxt = '0;
        if (words_r < WORD_LIMIT) begin
          words_nxt = words_r + NUM_W'(1);
        end
      end else if (closes) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end
    end

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + IDX_W'(1);
    end
    if (cmd.finish) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
      idx_nxt   = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      words_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      words_r     <= words_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Store write on a word character that still fits.
  always_ff @(posedge clk) begin
    if (cmd.take && !sep && room) begin
      store_mem[count_r[IDX_W-1:0]] <= to_lower(in_text_byte);
    end
  end

  // Registered store read straight into the output register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= store_mem[idx_r];
      out_num_r  <= words_r;
      out_end_r  <= sts.last_char;
      out_cut_r  <= ovf_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_word_number = out_num_r;
  assign out_word_end    = out_end_r;
  assign out_cut_short   = out_cut_r;

endmodule

### rtl/wtl_ctrl.sv
// ----------------------------------------------------------------------------
// wtl_ctrl: tokenizer controller
// Takes input bytes while idle and walks the word store out one character
// per free output slot when a word closes.
// ----------------------------------------------------------------------------
module wtl_ctrl
  import wtl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  wtl_sts_t sts,
  output wtl_cmd_t cmd
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SEND
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  // Commands and next state.
  always_comb begin
    cmd.take   = in_valid && in_ready_r;
    cmd.emit   = 1'b0;
    cmd.finish = 1'b0;
    state_nxt  = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.take && sts.word_ready) begin
          state_nxt = ST_SEND;
        end
      end
      ST_SEND: begin
        cmd.emit = sts.out_free;
        if (sts.out_free && sts.last_char) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    in_ready_nxt = (state_nxt == ST_IDLE);
  end

  // State and registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

### verif/tb_word_tokenizer_lowercase_top.sv
// ----------------------------------------------------------------------------
// tb_word_tokenizer_lowercase_top: self-checking bench for the word tokenizer
// A short scripted text opens the run and covers the byte classes, case
// folding, dropped one-letter words and end-of-text flushes. Random text
// follows: words with random content, long words past the store size, noise
// and runs of separators, with a stretch in the middle where neither side
// idles. Every output transfer is checked against a predictor that rebuilds
// each word from the accepted input bytes.
// ----------------------------------------------------------------------------
module tb_word_tokenizer_lowercase_top;
  import wtl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One character of an accepted word, as it leaves the block.
  typedef struct packed {
    logic [BYTE_W-1:0] chr;
    logic [NUM_W-1:0]  num;
    logic              last;
    logic              cut;
  } tok_char_t;

  // One row of the scripted text, with an optional typed-in closing character.
  typedef struct packed {
    logic [BYTE_W-1:0] text;
    logic              eot;
    logic              typed;
    tok_char_t         closing;
  } script_row_t;

  localparam int SCRIPT_ROWS  = 20;
  localparam int RANDOM_ITEMS = 340;
  localparam int SETTLE_WAIT  = 2 * MAX_WORD_CHARS + 8;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_text_byte = '0;
  logic              in_end_of_text = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic [NUM_W-1:0]  out_word_number;
  logic              out_word_end;
  logic              out_cut_short;

  // Predictor state: the pending word and the running word number.
  logic [BYTE_W-1:0] word_buf [MAX_WORD_CHARS];
  int                word_len;
  bit                word_over;
  logic [NUM_W-1:0]  word_tally;
  int                last_burst;

  tok_char_t         pending_chars [$];
  int                fault_count = 0;
  int                sent_items = 0;
  bit                sender_gaps = 1'b1;
  bit                receiver_stalls = 1'b1;

  // Scripted opening text. Typed rows carry the closing character of the
  // word they end; the rest of each word comes from the predictor.
  script_row_t script [SCRIPT_ROWS] = '{
    '{8'h41, 1'b0, 1'b0, '{8'h00, 16'd0, 1'b0, 1'b0}},  // 'A' folds to 'a'
    '{8'h7A, 1'b0, 1'b0, '{8'h00, 16'd0, 1'b0, 1'b0}},
    '{8'h00, 1'b0, 1'b1, '{8'h7A, 16'd1, 1'b1, 1'b0}},  // zero byte ends "az"
    '{8'h00, 1'b0, 1'b0, '{8'h00, 16'd0, 1'b0, 1'b0}},  // repeated separators
    '{8'hA0, 1'b0, 1'b0, '{8'h00, 16'd0, 1'b0, 1'b0}},
    '{8'h51, 1'b0, 1'b0, '{8'h00, 16'd0, 1'b0, 1'b0}},  // one letter, dropped
    '{8'h20, 1'b0, 1'b0, '{8'h00, 16'd0, 1'b0, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '{8'h00, 16'd0, 1'b0, 1'b0}},  // high bytes pass through
    '{8'h80, 1'b0, 1'b0, '{8'h00, 16'd0, 1'b0, 1'b0}},
    '{8'h5A, 1'b1, 1'b1, '{8'h7A, 16'd2, 1'b1, 1'b0}},  // end of text flushes
    '{8'h40, 1'b0, 1'b0, '{8'h00, 16'd0, 1'b0, 1'b0}},
    '{8'h5B, 1'b0, 1'b0, '{8'h00, 16'd0, 1'b0, 1'b0}},
    '{8'h60, 1'b0, 1'b0, '{8'h00, 16'd0, 1'b0, 1'b0}},
    '{8'h7B, 1'b0, 1'b0, '{8'h00, 16'd0, 1'b0, 1'b0}},
    '{8'h7F, 1'b0, 1'b0, '{8'h00, 16'd0, 1'b0, 1'b0}},
    '{8'h39, 1'b1, 1'b1, '{8'h7F, 16'd3, 1'b1, 1'b0}},  // digit with end of text
    '{8'h2E, 1'b1, 1'b0, '{8'h00, 16'd0, 1'b0, 1'b0}},  // empty text
    '{8'h78, 1'b1, 1'b0, '{8'h00, 16'd0, 1'b0, 1'b0}},  // one letter at the end
    '{8'h4D, 1'b0, 1'b0, '{8'h00, 16'd0, 1'b0, 1'b0}},
    '{8'h6D, 1'b1, 1'b1, '{8'h6D, 16'd4, 1'b1, 1'b0}}
  };

  word_tokenizer_lowercase_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_word_number (out_word_number),
    .out_word_end    (out_word_end),
    .out_cut_short   (out_cut_short)
  );

  always #1 clk = ~clk;

  // Bytes that close a word: 0x20..0x3F, [ \ ] ^ _, NUL, TAB, LF, VT, CR, NBSP.
  function automatic bit splits_word(input logic [BYTE_W-1:0] b);
    return (b >= 8'h20 && b <= 8'h3F) || (b >= 8'h5B && b <= 8'h5F) ||
           b == 8'h00 || b == 8'h09 || b == 8'h0A || b == 8'h0B ||
           b == 8'h0D || b == 8'hA0;
  endfunction

  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
  endfunction

  // Queues the characters of the pending word if it is long enough to send.
  function automatic void close_word();
    if (word_len >= 2) begin
      if (word_tally != WORD_LIMIT) begin
        word_tally = word_tally + 1'b1;
      end
      for (int i = 0; i < word_len; i++) begin
        pending_chars.push_back('{word_buf[i], word_tally, i == word_len - 1,
                                  word_over});
        last_burst++;
      end
    end
    word_len  = 0;
    word_over = 1'b0;
  endfunction

  // Predicts the characters released by one accepted input byte.
  function automatic void tokenize_byte(input logic [BYTE_W-1:0] b, input logic eot);
    last_burst = 0;
    if (splits_word(b)) begin
      close_word();
    end else begin
      if (word_len < MAX_WORD_CHARS) begin
        word_buf[word_len] = fold_case(b);
        word_len++;
      end else begin
        word_over = 1'b1;
      end
      if (eot) begin
        close_word();
      end
    end
  endfunction

  function automatic logic [BYTE_W-1:0] pick_word_char();
    logic [BYTE_W-1:0] b;
    if ($urandom_range(0, 1) == 0) begin
      return BYTE_W'($urandom_range(8'h41, 8'h5A));
    end
    do b = BYTE_W'($urandom_range(0, 255)); while (splits_word(b));
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_separator();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255)); while (!splits_word(b));
    return b;
  endfunction

  // Offers one byte, with an optional gap in front, and waits for its transfer.
  task automatic send_text(input logic [BYTE_W-1:0] b, input logic eot);
    while (sender_gaps && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    tokenize_byte(b, eot);
    sent_items++;
  endtask

  // One random group: a word, a long word, noise or a run of separators.
  task automatic send_random_group();
    int kind;
    int len;
    int ending;
    kind = $urandom_range(0, 15);
    if (kind <= 11) begin
      len    = (kind == 11) ? $urandom_range(MAX_WORD_CHARS - 2, MAX_WORD_CHARS + 9)
                            : $urandom_range(1, 8);
      ending = $urandom_range(0, 9);
      for (int i = 0; i < len; i++) begin
        send_text(pick_word_char(), (i == len - 1) && (ending inside {7, 8}));
      end
      if (ending <= 6 || ending == 9) begin
        send_text(pick_separator(), ending == 9);
      end
    end else if (kind <= 13) begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
        send_text(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end
    end else begin
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) begin
        send_text(pick_separator(), (i == len - 1) && $urandom_range(0, 3) == 0);
      end
    end
  endtask

  // Checks every output transfer against the oldest expected character.
  always @(posedge clk) begin
    tok_char_t got;
    tok_char_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_byte, out_word_number, out_word_end, out_cut_short};
        if (pending_chars.size() == 0) begin
          fault_count++;
          $display("%0t: unexpected transfer: byte %h word %0d end %b cut %b",
                   $time, got.chr, got.num, got.last, got.cut);
        end else begin
          want = pending_chars.pop_front();
          if (got != want) begin
            fault_count++;
            $display("%0t: expected byte %h word %0d end %b cut %b, got byte %h word %0d end %b cut %b",
                     $time, want.chr, want.num, want.last, want.cut,
                     got.chr, got.num, got.last, got.cut);
          end
        end
      end
      out_ready <= receiver_stalls ? ($urandom_range(0, 99) >= 27) : 1'b1;
    end
  end

  // Stimulus: scripted text, then random text.
  initial begin
    word_len   = 0;
    word_over  = 1'b0;
    word_tally = '0;
    last_burst = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Scripted opening text.
    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      send_text(script[r].text, script[r].eot);
      if (script[r].typed) begin
        if (last_burst == 0) begin
          pending_chars.push_back(script[r].closing);
        end else begin
          pending_chars[pending_chars.size() - 1] = script[r].closing;
        end
      end
    end

    // Random text, with a stretch in the middle where neither side idles.
    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      sender_gaps     = !(sent_items >= 150 && sent_items < 230);
      receiver_stalls = sender_gaps;
      send_random_group();
    end
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    in_valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
